// ===== rtl/core/pbdh_pkg.sv =====
// Shared constants, widths and the FNV-1a step for the palette blitter.
package pbdh_pkg;

  // Field widths
  localparam int CMD_W        = 1;
  localparam int ENTRY_W      = 8;
  localparam int COLOR_W      = 16;
  localparam int CODE_W       = 8;
  localparam int COL_W        = 8;
  localparam int LINE_W       = 9;
  localparam int WIDTH_REG_W  = 9;
  localparam int HEIGHT_REG_W = 10;
  localparam int HASH_W       = 32;

  // Geometry limits
  localparam int BATCH_ROWS   = 8;
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_BATCHES  = 64;
  localparam int MAX_LINES    = 512;
  localparam int PAL_DEPTH    = 256;

  localparam int BATCH_SHIFT  = $clog2(BATCH_ROWS);
  localparam int BATCH_W      = LINE_W - BATCH_SHIFT;
  localparam int SLOT_W       = $clog2(MAX_BATCHES);

  // Configuration port
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WIDTH_REG_W-1:0]  ROW_WIDTH_RST    = WIDTH_REG_W'(256);
  localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RST = HEIGHT_REG_W'(224);

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_PAL_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PIXEL     = 1'b1;

  // FNV-1a 32-bit
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;

  // One FNV-1a byte step; the prime is 2^24 + 403, so this maps to a few adders
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [CODE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ HASH_W'(b);
    return x * FNV_PRIME;
  endfunction

endpackage

// ===== rtl/core/pbdh_px_if.sv =====
// Input item channel: palette writes and pixel codes.
interface pbdh_px_if;
  import pbdh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [ENTRY_W-1:0]     entry_index;
  logic [COLOR_W-1:0]     entry_color;
  logic [CODE_W-1:0]      pixel_code;

  modport source (output valid, cmd, entry_index, entry_color, pixel_code, input ready);
  modport sink   (input valid, cmd, entry_index, entry_color, pixel_code, output ready);
endinterface

// ===== rtl/core/pbdh_res_if.sv =====
// Result channel: converted pixel with position and batch flags.
interface pbdh_res_if;
  import pbdh_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] rgb;
  logic [COL_W-1:0]   column;
  logic [LINE_W-1:0]  line;
  logic               batch_end;
  logic               batch_changed;
  logic               frame_end;

  modport source (output valid, rgb, column, line, batch_end, batch_changed, frame_end,
                  input ready);
  modport sink   (input valid, rgb, column, line, batch_end, batch_changed, frame_end,
                  output ready);
endinterface

// ===== rtl/core/pbdh_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface pbdh_cfg_if;
  import pbdh_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/palette_blit_dirty_batch_hash_unit.sv =====
// Top level: palette lookup, batch FNV-1a hashing and per-slot change detection.
//
//  Channel | Role   | Transfer carries
//  --------+--------+---------------------------------------------------------
//  px      | sink   | cmd, entry_index, entry_color, pixel_code
//  res     | source | rgb, column, line, batch_end, batch_changed, frame_end
//  cfg     | sink   | index, data (row_width = 0, frame_height = 1)
//
// One item per cycle is taken while px.ready is high; a pixel's result passes
// through the palette / hash RAM read, then the output register.
// The palette write of a cmd 0 item happens at its transfer and gives no result.
// Reset clears the valid marks, counters and hash at once; no clearing pass.
// px.ready drops only while both the compare stage and the output register are
// full and res is stalled. cfg is always ready.
module palette_blit_dirty_batch_hash_unit (
  input  logic clk,
  input  logic rst,
  pbdh_px_if.sink    px,
  pbdh_res_if.source res,
  pbdh_cfg_if.sink   cfg
);
  import pbdh_pkg::*;

  // Configuration and stream state
  logic [WIDTH_REG_W-1:0]  row_width;
  logic [HEIGHT_REG_W-1:0] frame_height;
  logic [COL_W-1:0]        col_count;
  logic [LINE_W-1:0]       line_count;
  logic [HASH_W-1:0]       running_hash;
  logic [MAX_BATCHES-1:0]  batch_valid;

  // Memories
  logic [COLOR_W-1:0] palette_mem [PAL_DEPTH];
  logic [HASH_W-1:0]  hash_mem    [MAX_BATCHES];
  logic [COLOR_W-1:0] pal_q;
  logic [HASH_W-1:0]  hash_q;

  // Front-end decode
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic                    last_col;
  logic                    last_line;
  logic                    batch_end0;
  logic [BATCH_W-1:0]      batch0;
  logic                    in_range0;
  logic [SLOT_W-1:0]       slot0;
  logic [HASH_W-1:0]       hash_new;

  // Compare stage
  logic               s1_valid;
  logic [COL_W-1:0]   s1_col;
  logic [LINE_W-1:0]  s1_line;
  logic               s1_batch_end;
  logic               s1_frame_end;
  logic               s1_in_range;
  logic [SLOT_W-1:0]  s1_slot;
  logic [HASH_W-1:0]  s1_hash;
  logic               s1_fwd;
  logic [HASH_W-1:0]  s1_fwd_hash;
  logic [HASH_W-1:0]  s1_old_hash;
  logic               s1_changed;
  logic               s1_wr;

  // Output register
  logic               s2_valid;

  // Handshake
  logic cfg_acc;
  logic px_acc;
  logic pix_acc;
  logic pal_we;
  logic s1_go;

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid && cfg.ready;

  assign s1_go    = s1_valid && (!s2_valid || res.ready);
  assign px.ready = !s1_valid || s1_go;
  assign px_acc   = px.valid && px.ready;
  assign pix_acc  = px_acc && (px.cmd == CMD_PIXEL);
  assign pal_we   = px_acc && (px.cmd == CMD_PAL_WRITE);

  // Effective geometry, clamped into range
  always_comb begin
    if (row_width == '0) begin
      w_eff = WIDTH_REG_W'(1);
    end else if (row_width > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = row_width;
    end
    if (frame_height == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (frame_height > HEIGHT_REG_W'(MAX_LINES)) begin
      h_eff = HEIGHT_REG_W'(MAX_LINES);
    end else begin
      h_eff = frame_height;
    end
  end

  // Position flags, batch slot and next hash for the pixel on the input
  always_comb begin
    last_col   = (WIDTH_REG_W'(col_count) + WIDTH_REG_W'(1)) >= w_eff;
    last_line  = (HEIGHT_REG_W'(line_count) + HEIGHT_REG_W'(1)) >= h_eff;
    batch_end0 = last_col &&
                 (last_line ||
                  (line_count[BATCH_SHIFT-1:0] == BATCH_SHIFT'(BATCH_ROWS - 1)));
    batch0     = line_count[LINE_W-1:BATCH_SHIFT];
    in_range0  = 32'(batch0) < MAX_BATCHES;
    slot0      = batch0[SLOT_W-1:0];
    hash_new   = fnv_step(running_hash, px.pixel_code);
  end

  // Configuration registers, counters, running hash and valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= ROW_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      col_count    <= '0;
      line_count   <= '0;
      running_hash <= FNV_BASIS;
      batch_valid  <= '0;
    end else if (cfg_acc) begin
      unique case (cfg.index)
        REG_ROW_WIDTH: begin
          row_width    <= cfg.data[WIDTH_REG_W-1:0];
          col_count    <= '0;
          line_count   <= '0;
          running_hash <= FNV_BASIS;
          batch_valid  <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg.data;
          col_count    <= '0;
          line_count   <= '0;
          running_hash <= FNV_BASIS;
          batch_valid  <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      if (pix_acc) begin
        running_hash <= batch_end0 ? FNV_BASIS : hash_new;
        if (last_col) begin
          col_count  <= '0;
          line_count <= last_line ? '0 : line_count + LINE_W'(1);
        end else begin
          col_count  <= col_count + COL_W'(1);
        end
      end
      if (s1_go && s1_wr) begin
        batch_valid[s1_slot] <= 1'b1;
      end
    end
  end

  // Palette RAM
  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette_mem[px.entry_index] <= px.entry_color;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      pal_q <= palette_mem[px.pixel_code];
    end
  end

  // Batch hash RAM: read at transfer, written back when the compare stage moves on
  assign s1_wr = s1_batch_end && s1_in_range;

  always_ff @(posedge clk) begin
    if (s1_go && s1_wr) begin
      hash_mem[s1_slot] <= s1_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc && batch_end0) begin
      hash_q <= hash_mem[slot0];
    end
  end

  // Compare stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Compare stage payload; forward a write-back to the same slot on the same edge
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_col       <= col_count;
      s1_line      <= line_count;
      s1_batch_end <= batch_end0;
      s1_frame_end <= last_col && last_line;
      s1_in_range  <= in_range0;
      s1_slot      <= slot0;
      s1_hash      <= hash_new;
      s1_fwd       <= s1_go && s1_wr && (s1_slot == slot0);
      s1_fwd_hash  <= s1_hash;
    end
  end

  // Change decision
  always_comb begin
    s1_old_hash = s1_fwd ? s1_fwd_hash : hash_q;
    s1_changed  = s1_batch_end &&
                  (!s1_in_range || !batch_valid[s1_slot] || (s1_old_hash != s1_hash));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go) begin
      s2_valid <= 1'b1;
    end else if (res.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res.rgb           <= pal_q;
      res.column        <= s1_col;
      res.line          <= s1_line;
      res.batch_end     <= s1_batch_end;
      res.batch_changed <= s1_changed;
      res.frame_end     <= s1_frame_end;
    end
  end

  assign res.valid = s2_valid;

  // Checks
  a_frame_end_is_batch_end: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!res.frame_end || res.batch_end))
    else $error("frame end without batch end");

  a_changed_only_at_batch_end: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!res.batch_changed || res.batch_end))
    else $error("batch changed flag outside batch end");

  a_counters_in_frame: assert property (@(posedge clk) disable iff (rst)
    (WIDTH_REG_W'(col_count) < w_eff) && (HEIGHT_REG_W'(line_count) < h_eff))
    else $error("pixel position outside frame geometry");

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for the palette blitter with per-batch FNV-1a change detection.
module testbench;
  import pbdh_pkg::*;

  localparam int DIRECTED_ROWS = 23;
  localparam int PHASES        = 7;
  localparam int SETTLE_CYCLES = 4;     // covers the two-stage result pipe
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 300;   // long result stall to back up the input
  localparam int STALL_LIMIT   = 4000;  // cycles with no transfer at all
  localparam int REPORT_MAX    = 10;

  // Register index outside the map; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ENTRY_W-1:0] entry_index;
    logic [COLOR_W-1:0] entry_color;
    logic [CODE_W-1:0]  pixel_code;
  } px_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] rgb;
    logic [COL_W-1:0]   column;
    logic [LINE_W-1:0]  line;
    logic               batch_end;
    logic               batch_changed;
    logic               frame_end;
  } pix_res_t;

  typedef enum logic {STEP_ITEM, STEP_REG} step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    px_item_t              item;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  typed;
    pix_res_t              want;
  } step_t;

  typedef struct {
    int width;
    int height;
    int frames;
    int tx_idle;
    int rx_stall;
    bit squeeze;
  } phase_t;

  logic clk = 1'b0;
  logic rst;

  pbdh_px_if  px ();
  pbdh_res_if res ();
  pbdh_cfg_if cfg ();

  palette_blit_dirty_batch_hash_unit i_dut (
    .clk (clk),
    .rst (rst),
    .px  (px),
    .res (res),
    .cfg (cfg)
  );

  always #5 clk = ~clk;

  // Predictor state: palette, slot signatures, running hash, raster position
  logic [COLOR_W-1:0]      shade_table [PAL_DEPTH];
  logic [HASH_W-1:0]       slot_sig [MAX_BATCHES];
  bit                      slot_seen [MAX_BATCHES];
  logic [HASH_W-1:0]       sig_acc;
  int                      col_pos;
  int                      row_pos;
  logic [WIDTH_REG_W-1:0]  geom_width;
  logic [HEIGHT_REG_W-1:0] geom_height;

  // Stimulus bookkeeping: which palette entries may be read
  bit                      shade_loaded [PAL_DEPTH];
  logic [CODE_W-1:0]       loaded_codes [$];

  pix_res_t                pending_pixels [$];
  pix_res_t                seen_px;
  pix_res_t                due_px;

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_seq;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_run  = 0;

  int mismatches = 0;
  int n_pixels;
  int n_pal_writes;
  int n_reg_writes;
  int n_changed = 0;
  int n_kept    = 0;
  int n_frames  = 0;

  step_t  directed_plan [DIRECTED_ROWS];
  phase_t phase_plan [PHASES];

  // ---------------------------------------------------------------- predictor

  function automatic void restart_raster();
    foreach (slot_seen[i]) slot_seen[i] = 1'b0;
    sig_acc = FNV_BASIS;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0]  idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ROW_WIDTH: begin
        geom_width = data[WIDTH_REG_W-1:0];
        restart_raster();
      end
      REG_FRAME_HEIGHT: begin
        geom_height = data[HEIGHT_REG_W-1:0];
        restart_raster();
      end
      default: ;
    endcase
  endfunction

  // One pixel: look up colour, fold byte into the hash, settle batch at its end
  function automatic pix_res_t predict_pixel(input logic [CODE_W-1:0] code);
    pix_res_t r;
    int       w;
    int       h;
    int       slot;
    bit       last_col;
    bit       last_line;
    w = (geom_width == 0) ? 1 : ((geom_width > MAX_WIDTH) ? MAX_WIDTH : int'(geom_width));
    h = (geom_height == 0) ? 1 : ((geom_height > MAX_LINES) ? MAX_LINES : int'(geom_height));
    sig_acc   = (sig_acc ^ HASH_W'(code)) * FNV_PRIME;
    last_col  = (col_pos + 1 >= w);
    last_line = (row_pos + 1 >= h);
    r.rgb           = shade_table[code];
    r.column        = COL_W'(col_pos);
    r.line          = LINE_W'(row_pos);
    r.batch_end     = last_col && (last_line || (row_pos % BATCH_ROWS) == BATCH_ROWS - 1);
    r.batch_changed = 1'b0;
    r.frame_end     = last_col && last_line;
    if (r.batch_end) begin
      slot = row_pos / BATCH_ROWS;
      if (slot < MAX_BATCHES) begin
        r.batch_changed = !slot_seen[slot] || (slot_sig[slot] != sig_acc);
        slot_sig[slot]  = sig_acc;
        slot_seen[slot] = 1'b1;
      end else begin
        r.batch_changed = 1'b1;
      end
      sig_acc = FNV_BASIS;
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_line ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  function automatic string show_px(input pix_res_t r);
    return $sformatf("rgb %h col %0d line %0d end %b changed %b frame %b",
                     r.rgb, r.column, r.line, r.batch_end, r.batch_changed, r.frame_end);
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Unused fields are randomised so every input bit toggles
  function automatic px_item_t palette_item(input logic [ENTRY_W-1:0] idx,
                                            input logic [COLOR_W-1:0] color);
    px_item_t it;
    it.cmd         = CMD_PAL_WRITE;
    it.entry_index = idx;
    it.entry_color = color;
    it.pixel_code  = CODE_W'($urandom);
    return it;
  endfunction

  function automatic px_item_t pixel_item(input logic [CODE_W-1:0] code);
    px_item_t it;
    it.cmd         = CMD_PIXEL;
    it.entry_index = ENTRY_W'($urandom);
    it.entry_color = COLOR_W'($urandom);
    it.pixel_code  = code;
    return it;
  endfunction

  // Random code, folded onto an entry that has been loaded
  function automatic logic [CODE_W-1:0] loaded_code();
    logic [CODE_W-1:0] c;
    c = CODE_W'($urandom);
    if (!shade_loaded[c]) c = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
    return c;
  endfunction

  function automatic step_t pal_row(input logic [ENTRY_W-1:0] idx,
                                    input logic [COLOR_W-1:0] color);
    step_t s;
    s      = '0;
    s.kind = STEP_ITEM;
    s.item = palette_item(idx, color);
    return s;
  endfunction

  function automatic step_t pix_row(input logic [CODE_W-1:0] code);
    step_t s;
    s      = '0;
    s.kind = STEP_ITEM;
    s.item = pixel_item(code);
    return s;
  endfunction

  function automatic step_t pix_row_exp(input logic [CODE_W-1:0] code,
                                        input logic [COLOR_W-1:0] rgb,
                                        input logic [COL_W-1:0] col,
                                        input logic [LINE_W-1:0] ln,
                                        input logic be, input logic ch, input logic fe);
    step_t s;
    s       = pix_row(code);
    s.typed = 1'b1;
    s.want  = {rgb, col, ln, be, ch, fe};
    return s;
  endfunction

  function automatic step_t reg_row(input logic [CFG_IDX_W-1:0]  idx,
                                    input logic [CFG_DATA_W-1:0] data);
    step_t s;
    s          = '0;
    s.kind     = STEP_REG;
    s.reg_idx  = idx;
    s.reg_data = data;
    return s;
  endfunction

  // Offer one item, hold it until the transfer, then book its palette write or expected result
  task automatic offer_item(input px_item_t it, input logic typed, input pix_res_t want);
    pix_res_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      px.valid <= 1'b0;
      @(posedge clk);
    end
    px.valid       <= 1'b1;
    px.cmd         <= it.cmd;
    px.entry_index <= it.entry_index;
    px.entry_color <= it.entry_color;
    px.pixel_code  <= it.pixel_code;
    do @(posedge clk); while (!px.ready);
    if (it.cmd == CMD_PAL_WRITE) begin
      shade_table[it.entry_index] = it.entry_color;
      if (!shade_loaded[it.entry_index]) begin
        shade_loaded[it.entry_index] = 1'b1;
        loaded_codes.push_back(it.entry_index);
      end
      n_pal_writes++;
    end else begin
      p = predict_pixel(it.pixel_code);
      pending_pixels.push_back(typed ? want : p);
      n_pixels++;
    end
  endtask

  // Register writes only once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    px.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    apply_reg(idx, data);
    n_reg_writes++;
  endtask

  // Frames of random content, mostly repeated so unchanged batches occur
  task automatic run_phase(input phase_t ph);
    logic [CODE_W-1:0] codes [$];
    int                n;
    int                cut;
    int                pick;
    int                f;
    int                i;
    tx_idle_pct  = ph.tx_idle;
    rx_stall_pct = ph.rx_stall;
    write_reg(REG_ROW_WIDTH, CFG_DATA_W'(ph.width));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(ph.height));
    if ($urandom_range(2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(15, 2)), CFG_DATA_W'($urandom));
    if (ph.squeeze) hold_seq = hold_seq + 1;
    n = ph.width * ph.height;
    for (f = 0; f < ph.frames; f++) begin
      pick = $urandom_range(9);
      if (f == 0 || pick >= 8) begin
        codes.delete();
        repeat (n) codes.push_back(loaded_code());
      end else if (pick >= 6) begin
        codes[$urandom_range(n - 1)] = loaded_code();
      end
      // occasionally break the first frame off and restart the raster
      cut = n;
      if (f == 0 && ph.frames > 1 && $urandom_range(1) == 1) cut = $urandom_range(n - 1, 1);
      for (i = 0; i < cut; i++) begin
        if ($urandom_range(99) < 15)
          offer_item(palette_item(ENTRY_W'($urandom), COLOR_W'($urandom)), 1'b0, '0);
        offer_item(pixel_item(codes[i]), 1'b0, '0);
      end
      if (cut < n) write_reg(REG_ROW_WIDTH, CFG_DATA_W'(ph.width));
    end
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
      // check each transfer against the oldest expectation
      if (res.valid && res.ready) begin
        seen_px.rgb           = res.rgb;
        seen_px.column        = res.column;
        seen_px.line          = res.line;
        seen_px.batch_end     = res.batch_end;
        seen_px.batch_changed = res.batch_changed;
        seen_px.frame_end     = res.frame_end;
        if (seen_px.batch_end) begin
          if (seen_px.batch_changed) n_changed++;
          else n_kept++;
        end
        if (seen_px.frame_end) n_frames++;
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: %s", show_px(seen_px));
        end else begin
          due_px = pending_pixels.pop_front();
          if (seen_px !== due_px) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: expected %s / actual %s", show_px(due_px),
                       show_px(seen_px));
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((px.valid && px.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        idle_run = 0;
      else
        idle_run = idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding", idle_run,
                 pending_pixels.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst             <= 1'b1;
    px.valid        <= 1'b0;
    px.cmd          <= CMD_PAL_WRITE;
    px.entry_index  <= '0;
    px.entry_color  <= '0;
    px.pixel_code   <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= '0;
    cfg.data        <= '0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    hold_seq        = 0;
    n_pixels        = 0;
    n_pal_writes    = 0;
    n_reg_writes    = 0;

    foreach (shade_table[i]) begin
      shade_table[i]  = '0;
      shade_loaded[i] = 1'b0;
    end
    foreach (slot_sig[i]) slot_sig[i] = '0;
    geom_width  = ROW_WIDTH_RST;
    geom_height = FRAME_HEIGHT_RST;
    restart_raster();

    // Directed: colour extremes, 1x1 frames for the change flag, clamped geometry,
    // an ignored register index and a palette rewrite
    directed_plan = '{
      pal_row(8'h00, 16'h0000),
      pal_row(8'hFF, 16'hFFFF),
      pal_row(8'hA5, 16'h5AA5),
      pal_row(8'h5A, 16'hA55A),
      pix_row_exp(8'hFF, 16'hFFFF, 8'd0, 9'd0, 1'b0, 1'b0, 1'b0),
      pix_row_exp(8'h00, 16'h0000, 8'd1, 9'd0, 1'b0, 1'b0, 1'b0),
      pix_row(8'hA5),
      reg_row(REG_ROW_WIDTH, 10'd1),
      reg_row(REG_FRAME_HEIGHT, 10'd1),
      pix_row_exp(8'hFF, 16'hFFFF, 8'd0, 9'd0, 1'b1, 1'b1, 1'b1),
      pix_row_exp(8'hFF, 16'hFFFF, 8'd0, 9'd0, 1'b1, 1'b0, 1'b1),
      pix_row_exp(8'h00, 16'h0000, 8'd0, 9'd0, 1'b1, 1'b1, 1'b1),
      reg_row(REG_ROW_WIDTH, 10'd0),
      reg_row(REG_FRAME_HEIGHT, 10'd0),
      pix_row_exp(8'h5A, 16'hA55A, 8'd0, 9'd0, 1'b1, 1'b1, 1'b1),
      reg_row(REG_SPARE, 10'h3FF),
      pix_row_exp(8'h5A, 16'hA55A, 8'd0, 9'd0, 1'b1, 1'b0, 1'b1),
      reg_row(REG_ROW_WIDTH, 10'h3FF),
      reg_row(REG_FRAME_HEIGHT, 10'h3FF),
      pix_row(8'hA5),
      pix_row(8'h5A),
      pal_row(8'h00, 16'hFFFF),
      pix_row_exp(8'h00, 16'hFFFF, 8'd2, 9'd0, 1'b0, 1'b0, 1'b0)
    };

    // Geometry, frames, sender idle %, receiver stall %, long result hold-off
    phase_plan = '{
      '{3,   9,   2, 0,  0,  1'b0},
      '{4,   5,   2, 84, 0,  1'b0},
      '{2,   11,  2, 0,  84, 1'b0},
      '{5,   3,   2, 38, 38, 1'b0},
      '{6,   8,   1, 0,  0,  1'b1},
      '{32,  2,   1, 0,  0,  1'b0},
      '{1,   64,  1, 38, 38, 1'b0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      if (directed_plan[k].kind == STEP_REG)
        write_reg(directed_plan[k].reg_idx, directed_plan[k].reg_data);
      else
        offer_item(directed_plan[k].item, directed_plan[k].typed, directed_plan[k].want);
    end

    for (int k = 0; k < PHASES; k++) run_phase(phase_plan[k]);

    px.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pixels, %0d palette loads, %0d register writes, %0d geometries",
             n_pixels, n_pal_writes, n_reg_writes, PHASES + 4);
    $display("batches redrawn %0d, batches unchanged %0d, frames completed %0d",
             n_changed, n_kept, n_frames);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
